// ===== design/cvwta_pkg.sv =====
// shared types and constants for the cost volume winner-take-all block
package cvwta_pkg;

  localparam int unsigned XW      = 5;
  localparam int unsigned YW      = 5;
  localparam int unsigned LVW     = 6;
  localparam int unsigned INCW    = 16;
  localparam int unsigned COSTW   = 32;
  localparam int unsigned SCALEW  = 17;
  localparam int unsigned OUTSW   = 16;
  localparam int unsigned ADDRW   = LVW + YW + XW;
  localparam int unsigned CFGAW   = 1;
  localparam int unsigned CFGDW   = SCALEW;

  localparam logic [COSTW-1:0] COST_MAX  = 32'h7fff_ffff;
  localparam logic [COSTW-1:0] COST_NONE = 32'hffff_ffff;

  localparam logic [LVW-1:0]    RST_MAX_DISP = 6'd63;
  localparam logic [SCALEW-1:0] RST_SCALE    = 17'd1024;

  localparam logic OP_ACC   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFGAW-1:0] REG_MAX_DISP = 1'b0;
  localparam logic [CFGAW-1:0] REG_SCALE    = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             we;
    logic [ADDRW-1:0] addr;
    logic [COSTW-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [LVW-1:0]   best_level;
    logic [COSTW-1:0] best_cost;
  } res_t;

endpackage

// ===== design/cvwta_ram.sv =====
// single port synchronous ram with registered read data
module cvwta_ram #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/cvwta_seq.sv =====
// sequencer: clearing pass, accumulate read-modify-write and level scan
module cvwta_seq
  import cvwta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [XW-1:0]    pixel_x,
  input  logic [YW-1:0]    pixel_y,
  input  logic [LVW-1:0]   level,
  input  logic [INCW-1:0]  cost,
  input  logic [LVW-1:0]   max_disparity,
  input  logic             out_free,
  input  logic [COSTW-1:0] rdata,
  output ram_req_t         req,
  output res_t             res
);

  state_t state, state_next;

  logic [XW-1:0]    px;
  logic [YW-1:0]    py;
  logic [LVW-1:0]   lv;
  logic [INCW-1:0]  inc;
  logic [LVW-1:0]   lv_cnt;
  logic [ADDRW-1:0] clr_cnt;
  logic             pend;
  logic [LVW-1:0]   pend_lv;
  logic [LVW-1:0]   best_lv;
  logic [COSTW-1:0] best_cost;
  logic [COSTW:0]   sum;
  logic [COSTW-1:0] upd;
  logic             take;

  // saturating update of a stored entry; an unwritten (negative) entry takes the new cost
  always_comb begin
    sum = {1'b0, rdata} + {{(COSTW + 1 - INCW){1'b0}}, inc};
    if (rdata[COSTW-1]) begin
      upd = {{(COSTW - INCW){1'b0}}, inc};
    end else if (sum[COSTW:COSTW-1] != 2'b00) begin
      upd = COST_MAX;
    end else begin
      upd = sum[COSTW-1:0];
    end
  end

  assign take = pend && ($signed(rdata) < $signed(best_cost));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    req.we     = 1'b0;
    req.addr   = {lv, py, px};
    req.wdata  = upd;
    case (state)
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = clr_cnt;
        req.wdata = COST_NONE;
        if (clr_cnt == {ADDRW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op == OP_QUERY) begin
            state_next = ST_SCAN;
          end else if (level <= max_disparity) begin
            state_next = ST_ACC_RD;
          end
        end
      end
      ST_ACC_RD: begin
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        req.we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        req.addr = {lv_cnt, py, px};
        if (lv_cnt == max_disparity) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pend    <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      pend <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    pend_lv <= lv_cnt;
    if (state == ST_IDLE && in_valid) begin
      px        <= pixel_x;
      py        <= pixel_y;
      lv        <= level;
      inc       <= cost;
      lv_cnt    <= '0;
      best_lv   <= '0;
      best_cost <= COST_MAX;
    end else begin
      if (state == ST_SCAN) begin
        lv_cnt <= lv_cnt + 1'b1;
      end
      if (take) begin
        best_lv   <= pend_lv;
        best_cost <= rdata;
      end
    end
  end

  assign res.valid      = (state == ST_DONE);
  assign res.x          = px;
  assign res.y          = py;
  assign res.best_level = best_lv;
  assign res.best_cost  = best_cost;

endmodule

// ===== design/cost_volume_winner_take_all_core.sv =====
// top level: configuration registers, cost volume ram, sequencer and result register
//
// input stream s_*: one request per beat, s_tuser is the op (0 accumulate, 1 query);
// s_tdata carries pixel_x, pixel_y, level and cost. output stream m_*: one result
// per query with the pixel, the winning level, its cost and level times scale.
// config: cfg_we writes cfg_wdata into register cfg_addr (0 max_disparity,
// 1 disparity_scale) in the same cycle; the user must write only while the block is idle,
// which the block does not enforce. after reset a clearing pass writes -1 into
// all 65536 entries, one per cycle; s_tready stays low for the whole pass.
// an accumulate passes through accept, read and write back;
// an accumulate above max_disparity is accepted and dropped without a ram access.
// a query makes one ram read per level, levels 0 to max_disparity, through the
// single ram port, then the compare of the last level and the result load.
// one request is in work at a time; s_tready is high only when the sequencer is idle.
// the result register holds a finished result while m_tready is low; the next
// request is taken meanwhile, and a later query waits for that register to empty.
module cost_volume_winner_take_all_core
  import cvwta_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,    // pixel_x, pixel_y, level, cost
  input  logic             s_tuser,    // op
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [63:0]      m_tdata,    // out_x, out_y, best_level, best_cost, scaled_disparity
  input  logic             cfg_we,
  input  logic [CFGAW-1:0] cfg_addr,
  input  logic [CFGDW-1:0] cfg_wdata
);

  logic [LVW-1:0]    max_disparity;
  logic [SCALEW-1:0] disparity_scale;
  logic              out_free;
  logic [COSTW-1:0]  rdata;
  ram_req_t          req;
  res_t              res;
  logic [OUTSW-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_disparity   <= RST_MAX_DISP;
      disparity_scale <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_DISP: max_disparity   <= cfg_wdata[LVW-1:0];
        REG_SCALE:    disparity_scale <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  cvwta_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .op            (s_tuser),
    .pixel_x       (s_tdata[4:0]),
    .pixel_y       (s_tdata[9:5]),
    .level         (s_tdata[15:10]),
    .cost          (s_tdata[31:16]),
    .max_disparity (max_disparity),
    .out_free      (out_free),
    .rdata         (rdata),
    .req           (req),
    .res           (res)
  );

  cvwta_ram #(
    .ADDR_W (ADDRW),
    .DATA_W (COSTW)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  // only the low 16 bits of the product survive
  always_comb begin
    logic [OUTSW+LVW-1:0] prod;
    prod   = {{OUTSW{1'b0}}, res.best_level} * {{LVW{1'b0}}, disparity_scale[OUTSW-1:0]};
    scaled = prod[OUTSW-1:0];
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      m_tdata <= {scaled, res.best_cost, res.best_level, res.y, res.x};
    end
  end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the cost volume winner-take-all core
module tb;
  import cvwta_pkg::*;

  typedef struct packed {
    logic [15:0] cost;
    logic [5:0]  level;
    logic [4:0]  y;
    logic [4:0]  x;
  } wta_req_t;

  typedef struct packed {
    logic [15:0]        scaled;
    logic signed [31:0] cost;
    logic [5:0]         level;
    logic [4:0]         y;
    logic [4:0]         x;
  } wta_result_t;

  localparam longint SAT_COST = 64'sd2147483647;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;    // pixel_x, pixel_y, level, cost
  logic              s_tuser = 1'b0;  // op
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [63:0]       m_tdata;         // out_x, out_y, best_level, best_cost, scaled_disparity
  logic              cfg_we = 1'b0;
  logic [CFGAW-1:0]  cfg_addr = '0;
  logic [CFGDW-1:0]  cfg_wdata = '0;

  cost_volume_winner_take_all_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  int          volume [0:65535];
  logic [5:0]  top_disp;
  logic [16:0] scale_reg;
  wta_result_t winners_q [$];

  int mismatches = 0;
  int n_acc = 0;
  int n_query = 0;
  int n_checked = 0;
  int n_settings = 0;

  // sender burst state
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver pattern state
  bit hold_ask = 1'b0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int run_left = 0;
  bit rx_level = 1'b1;

  task automatic predict_request(input logic op, input wta_req_t r);
    longint      sum;
    int          best_c;
    int          best_d;
    int          v;
    wta_result_t res;
    if (op == OP_ACC) begin
      if (r.level <= top_disp) begin
        v = volume[{r.level, r.y, r.x}];
        if (v < 0) begin
          volume[{r.level, r.y, r.x}] = int'(r.cost);
        end else begin
          sum = longint'(v) + longint'(r.cost);
          if (sum > SAT_COST) sum = SAT_COST;
          volume[{r.level, r.y, r.x}] = int'(sum);
        end
      end
    end else begin
      best_c = int'(SAT_COST);
      best_d = 0;
      for (int d = 0; d <= int'(top_disp); d++) begin
        v = volume[{6'(d), r.y, r.x}];
        if (v < best_c) begin
          best_c = v;
          best_d = d;
        end
      end
      res.x = r.x;
      res.y = r.y;
      res.level = 6'(best_d);
      res.cost = best_c;
      res.scaled = 16'(best_d * int'(scale_reg));
      winners_q.push_back(res);
    end
  endtask

  task automatic send_request(input logic op, input wta_req_t r);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= r;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(op, r);
    if (op == OP_QUERY) n_query++;
    else n_acc++;
  endtask

  task automatic accumulate_cost(input logic [4:0] x, input logic [4:0] y,
                                 input logic [5:0] lv, input logic [15:0] c);
    wta_req_t r;
    r = '{cost: c, level: lv, y: y, x: x};
    send_request(OP_ACC, r);
  endtask

  task automatic query_pixel(input logic [4:0] x, input logic [4:0] y);
    wta_req_t r;
    r = '{cost: 16'($urandom), level: 6'($urandom), y: y, x: x};
    send_request(OP_QUERY, r);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (winners_q.size() != 0) @(posedge clk);
    // an accumulate may still be writing back
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] md, input logic [16:0] sc);
    drain_results();
    cfg_we <= 1'b1;
    cfg_addr <= REG_MAX_DISP;
    cfg_wdata <= CFGDW'(md);
    @(posedge clk);
    top_disp = md;
    cfg_addr <= REG_SCALE;
    cfg_wdata <= sc;
    @(posedge clk);
    scale_reg = sc;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic report_field(input string name, input longint got_v, input longint want_v);
    if (got_v != want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d got %0d", name, want_v, got_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    wta_result_t got;
    wta_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (winners_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: x %0d y %0d level %0d cost %0d scaled %0d",
                   got.x, got.y, got.level, got.cost, got.scaled);
      end else begin
        want = winners_q.pop_front();
        n_checked++;
        report_field("out_x", got.x, want.x);
        report_field("out_y", got.y, want.y);
        report_field("best_level", got.level, want.level);
        report_field("best_cost", longint'(got.cost), longint'(want.cost));
        report_field("scaled_disparity", got.scaled, want.scaled);
      end
    end
  end

  // output stall pattern, with an occasional long hold-off
  always @(posedge clk) begin : rx_pattern
    bit nxt;
    if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = 400;
    end
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b0;
    end else begin
      case (rx_mode)
        0: nxt = 1'b1;
        1: nxt = 1'($urandom_range(0, 1));
        2: nxt = ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left <= 0) begin
            rx_level = ~rx_level;
            run_left = $urandom_range(1, 20);
          end
          run_left--;
          nxt = rx_level;
        end
      endcase
    end
    m_tready <= nxt;
  end

  task automatic test_directed_cases();
    gaps_on = 1'b1;
    // unwritten volume at reset settings
    query_pixel(5'd0, 5'd0);
    query_pixel(5'd31, 5'd31);
    accumulate_cost(5'd31, 5'd31, 6'd63, 16'hffff);
    accumulate_cost(5'd0, 5'd0, 6'd0, 16'h0000);
    query_pixel(5'd0, 5'd0);
    accumulate_cost(5'd0, 5'd0, 6'd0, 16'h0000);
    query_pixel(5'd31, 5'd31);
    // ties go to the lower level, scale with only bit 16 set
    set_config(6'd2, 17'h10000);
    accumulate_cost(5'd7, 5'd3, 6'd0, 16'd500);
    accumulate_cost(5'd7, 5'd3, 6'd1, 16'd200);
    accumulate_cost(5'd7, 5'd3, 6'd2, 16'd200);
    accumulate_cost(5'd7, 5'd3, 6'd3, 16'd5);
    query_pixel(5'd7, 5'd3);
    accumulate_cost(5'd7, 5'd3, 6'd1, 16'd1);
    query_pixel(5'd7, 5'd3);
    accumulate_cost(5'd7, 5'd3, 6'd0, 16'hffff);
    query_pixel(5'd7, 5'd3);
    // ignored level stays unwritten once scanned
    set_config(6'd63, 17'd0);
    query_pixel(5'd7, 5'd3);
    query_pixel(5'd31, 5'd31);
    // single stored level
    set_config(6'd0, 17'd1);
    query_pixel(5'd31, 5'd31);
    accumulate_cost(5'd31, 5'd31, 6'd0, 16'd9);
    accumulate_cost(5'd31, 5'd31, 6'd1, 16'd4);
    query_pixel(5'd31, 5'd31);
  endtask

  task automatic test_large_sums();
    set_config(6'd0, 17'd3);
    gaps_on = 1'b0;
    for (int i = 0; i < 64; i++) begin
      accumulate_cost(5'd12, 5'd20, 6'd0, 16'hffff);
      if (i % 16 == 0) accumulate_cost(5'd12, 5'd20, 6'($urandom_range(1, 63)), 16'd1);
      if (i == 31 || i == 32) query_pixel(5'd12, 5'd20);
    end
    query_pixel(5'd12, 5'd20);
    accumulate_cost(5'd12, 5'd20, 6'd0, 16'd1);
    query_pixel(5'd12, 5'd20);
    // the large entry at level 0 against unwritten upper levels
    set_config(6'd1, 17'd65535);
    query_pixel(5'd12, 5'd20);
  endtask

  task automatic test_output_stall();
    set_config(6'd5, 17'd700);
    gaps_on = 1'b0;
    hold_ask = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) query_pixel(5'd9, 5'd14);
      else accumulate_cost(5'd9, 5'd14, 6'($urandom_range(0, 5)), 16'($urandom));
    end
  endtask

  task automatic test_random_phases();
    logic [5:0]  tops [8] = '{6'd63, 6'd1, 6'd17, 6'd4, 6'd62, 6'd2, 6'd31, 6'd9};
    logic [4:0]  pool_x [3];
    logic [4:0]  pool_y [3];
    logic [16:0] sc;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [5:0]  lv;
    logic [15:0] c;
    int          npool;
    int          nitems;
    int          pick;
    int          q_pct;
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: sc = 17'($urandom_range(0, 65536));
        1: sc = 17'h10000;
        2: sc = 17'd0;
        default: sc = 17'(65536 / int'(tops[p]));
      endcase
      set_config(tops[p], sc);
      gaps_on = ($urandom_range(0, 3) != 0);
      npool = (tops[p] > 12) ? 1 : 3;
      nitems = (tops[p] > 12) ? 260 : 150;
      q_pct = (tops[p] > 12) ? 20 : 30;
      for (int k = 0; k < 3; k++) begin
        pool_x[k] = 5'($urandom);
        pool_y[k] = 5'($urandom);
      end
      for (int i = 0; i < nitems; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          x = 5'($urandom);
          y = 5'($urandom);
        end else begin
          pick = $urandom_range(0, npool - 1);
          x = pool_x[pick];
          y = pool_y[pick];
        end
        if ($urandom_range(0, 99) < q_pct) begin
          query_pixel(x, y);
        end else begin
          if ($urandom_range(0, 99) < 85) lv = 6'($urandom_range(0, int'(tops[p])));
          else lv = 6'($urandom);
          case ($urandom_range(0, 9))
            6, 7: c = 16'($urandom_range(0, 7));
            8: c = 16'hffff;
            9: c = 16'h0000;
            default: c = 16'($urandom);
          endcase
          accumulate_cost(x, y, lv, c);
        end
      end
    end
  endtask

  initial begin
    foreach (volume[i]) volume[i] = -1;
    top_disp = RST_MAX_DISP;
    scale_reg = RST_SCALE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    test_directed_cases();
    test_large_sums();
    test_output_stall();
    test_random_phases();
    drain_results();
    repeat (70) @(posedge clk);
    $display("covered %0d accumulate and %0d query requests over %0d register settings",
             n_acc, n_query, n_settings);
    $display("checked %0d results, including long accumulations and a long output stall",
             n_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", winners_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
